// ===== rtl/linear_probe_hash_table_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the linear probe hash table
// Shorthand for the clocked implication checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht: next-cycle check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table package
// Action and status codes, register indexes and the modulo unit response type.
// ---------------------------------------------------------------------------
package lpht_pkg;

    // Width of the hash value, the configuration registers and the divisor.
    localparam int HASH_W = 8;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] STS_INSERTED   = 3'd0;
    localparam logic [2:0] STS_FULL       = 3'd1;
    localparam logic [2:0] STS_FOUND      = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
    localparam logic [2:0] STS_CLEARED    = 3'd4;
    localparam logic [2:0] STS_BAD_CONFIG = 3'd5;

    // Register indexes on the configuration port.
    localparam logic REG_TABLE_SIZE   = 1'b0;
    localparam logic REG_HASH_DIVISOR = 1'b1;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] rem;
    } lpht_mod_rsp_t;

endpackage

// ===== rtl/linear_probe_hash_table_top.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing hash table with division hashing and linear probing.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                          Carries
//  -------   ------------------------------   -----------------------------------
//  s_axis    tvalid tready tdata tuser        one request: action, key
//  m_axis    tvalid tready tdata tuser        one response: slot, comparisons, status
//  apb       psel penable pwrite paddr ...    table_size, hash_divisor registers
//
// An insert or search is accepted in the idle state, runs the bit-serial modulo unit,
// then for each slot probed does a registered memory read and a compare, and finally
// loads the response register.
// A clear sweeps the table memory one slot per cycle, then loads the response register.
// After reset the same sweep runs over the whole table before s_axis_tready rises.
// A response waits in the output register while m_axis_tready is low; the next
// request is accepted meanwhile and its response waits for that register.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_top_assert.svh"

module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_BITS    = 15
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // key
    input  logic [1:0]                          s_axis_tuser,  // action

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // slot[6:0], comparisons[14:7]
    output logic [2:0]                          m_axis_tuser,  // status

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Address width of the slot memory and width of a probe position.
    localparam int AW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW  = (AW > HASH_W) ? AW : HASH_W;
    // Largest usable table size: bounded by the memory and by the 8-bit register.
    localparam int CAP = (TABLE_DEPTH > 255) ? 255 : TABLE_DEPTH;
    localparam int MW  = KEY_BITS + 1;

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HASH  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_PROBE = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [HASH_W-1:0]   table_size_reg, hash_divisor_reg;
    logic [HASH_W-1:0]   eff_size;
    logic                cfg_wr;

    logic [1:0]          action_reg, action_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       home_reg, home_next;
    logic [HASH_W-1:0]   comps_reg, comps_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;

    logic [6:0]          res_slot_reg, res_slot_next;
    logic [HASH_W-1:0]   res_comps_reg, res_comps_next;
    logic [2:0]          res_status_reg, res_status_next;

    logic                out_valid_reg, out_valid_next;
    logic [6:0]          out_slot_reg, out_slot_next;
    logic [HASH_W-1:0]   out_comps_reg, out_comps_next;
    logic [2:0]          out_status_reg, out_status_next;

    logic [MW-1:0]       slot_mem [TABLE_DEPTH];
    logic [MW-1:0]       rd_q_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;

    logic                in_xfer;
    logic                mod_start;
    lpht_mod_rsp_t       mod_rsp;

    logic [PW-1:0]       pos_inc;
    logic [PW-1:0]       pos_wrap;
    logic                slot_used;
    logic [KEY_BITS-1:0] slot_key;

    // -----------------------------------------------------------------------
    // Configuration port. Only paddr[2] selects the register; pready is tied
    // high, so every access completes in its access cycle.
    // -----------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= 8'd128;
            hash_divisor_reg <= 8'd127;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TABLE_SIZE:   table_size_reg   <= pwdata[HASH_W-1:0];
                REG_HASH_DIVISOR: hash_divisor_reg <= pwdata[HASH_W-1:0];
                default:          table_size_reg   <= table_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TABLE_SIZE:   prdata = {24'd0, table_size_reg};
            REG_HASH_DIVISOR: prdata = {24'd0, hash_divisor_reg};
            default:          prdata = '0;
        endcase
    end

    // A size larger than the memory behaves as the full memory.
    assign eff_size = (table_size_reg > HASH_W'(CAP)) ? HASH_W'(CAP) : table_size_reg;

    // -----------------------------------------------------------------------
    // Home slot: key mod hash_divisor, computed bit-serially. The unit loads
    // the key straight from the request at the accepting edge.
    // -----------------------------------------------------------------------
    lpht_mod #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (s_axis_tdata[KEY_BITS-1:0]),
        .divisor  (hash_divisor_reg),
        .rsp      (mod_rsp)
    );

    // -----------------------------------------------------------------------
    // Slot memory. Each word holds the occupied flag above the stored key.
    // The read port always follows the current probe position; its data is
    // registered and examined in the cycle after the address was presented.
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= slot_mem[pos_reg[AW-1:0]];
    end

    assign slot_used = rd_q_reg[MW-1];
    assign slot_key  = rd_q_reg[KEY_BITS-1:0];

    // Next probe position, wrapping at the effective table size.
    assign pos_inc  = pos_reg + 1'b1;
    assign pos_wrap = (pos_inc == PW'(eff_size)) ? '0 : pos_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // -----------------------------------------------------------------------
    // Sequencer.
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        home_next       = home_reg;
        comps_next      = comps_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_slot_next   = res_slot_reg;
        res_comps_next  = res_comps_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_comps_next  = out_comps_reg;
        out_status_next = out_status_reg;
        mod_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = '0;

        // The consumer took the waiting response.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // Sweep the memory, marking every slot empty.
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_slot_next   = '0;
                        res_comps_next  = '0;
                        res_status_next = STS_CLEARED;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    action_next    = s_axis_tuser;
                    key_next       = s_axis_tdata[KEY_BITS-1:0];
                    res_slot_next  = '0;
                    res_comps_next = '0;
                    if (s_axis_tuser == ACT_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if ((s_axis_tuser != ACT_INSERT && s_axis_tuser != ACT_SEARCH)
                             || hash_divisor_reg == '0 || eff_size == '0)
                    begin
                        res_status_next = STS_BAD_CONFIG;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                // The modulo unit was started at the accepting edge.
                if (mod_rsp.done)
                begin
                    if (mod_rsp.rem >= eff_size)
                    begin
                        res_status_next = STS_BAD_CONFIG;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = PW'(mod_rsp.rem);
                        home_next  = PW'(mod_rsp.rem);
                        comps_next = '0;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (action_reg == ACT_INSERT)
                begin
                    if (!slot_used)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = pos_reg[AW-1:0];
                        mem_wdata       = {1'b1, key_reg};
                        res_slot_next   = pos_reg[6:0];
                        res_status_next = STS_INSERTED;
                        state_next      = ST_DONE;
                    end
                    else if (pos_wrap == home_reg)
                    begin
                        res_status_next = STS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_wrap;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    if (slot_used && comps_reg < eff_size)
                    begin
                        comps_next = comps_reg + 1'b1;
                        if (slot_key == key_reg)
                        begin
                            res_slot_next   = pos_reg[6:0];
                            res_comps_next  = comps_reg + 1'b1;
                            res_status_next = STS_FOUND;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = pos_wrap;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        res_comps_next  = comps_reg;
                        res_status_next = STS_NOT_FOUND;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                // Move the response into the output register once it is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_comps_next  = res_comps_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        home_reg       <= home_next;
        comps_reg      <= comps_next;
        res_slot_reg   <= res_slot_next;
        res_comps_reg  <= res_comps_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_comps_reg  <= out_comps_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_comps_reg, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;

    // -----------------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------------
    `LPHT_ASSERT_IMP(a_mod_done_in_hash, clk, rst_n, mod_rsp.done, state_reg == ST_HASH)
    `LPHT_ASSERT_IMP(a_comps_bounded, clk, rst_n, state_reg == ST_PROBE, comps_reg <= eff_size)
    `LPHT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_xfer, !s_axis_tready)

endmodule

// ===== rtl/lpht_mod.sv =====
// ---------------------------------------------------------------------------
// Iterative modulo unit
// Restoring remainder calculation, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module lpht_mod
    import lpht_pkg::*;
#(
    parameter int KEY_BITS = 15
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] dividend,
    input  logic [HASH_W-1:0]   divisor,
    output lpht_mod_rsp_t       rsp
);

    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] q_reg, q_next;
    logic [HASH_W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [HASH_W:0]     trial;

    // The shared subtract and compare: shift in the next bit, subtract if it fits.
    assign trial = {rem_reg, q_reg[KEY_BITS-1]};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CW'(KEY_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[KEY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = HASH_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[HASH_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== tb/lpht_checker.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table checker
// Watches the request, response and register channels, keeps its own copy
// of the table and the registers, and compares every response with the oldest
// outstanding prediction.
// ---------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key[14:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // action

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // slot[6:0], comparisons[14:7], zero pad
    input  logic [2:0]  m_axis_tuser,   // status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          failures,
    output int          outstanding
);

    typedef struct packed {
        logic [6:0] slot;
        logic [7:0] comps;
        logic [2:0] status;
    } lookup_reply_t;

    logic [7:0]    cfg_table_size;
    logic [7:0]    cfg_hash_divisor;
    logic [DEPTH-1:0] occupied;
    logic [14:0]   stored_key [DEPTH];
    lookup_reply_t pending_replies [$];

    // Applies one request to the local table and returns the response it must give.
    function automatic lookup_reply_t probe_table(input logic [1:0] act, input logic [14:0] key);
        lookup_reply_t r;
        int size;
        int home;
        int pos;
        int comps;
        r = '0;
        r.status = STS_BAD_CONFIG;
        size = (cfg_table_size > DEPTH) ? DEPTH : int'(cfg_table_size);
        if (act == ACT_CLEAR)
        begin
            occupied = '0;
            r.status = STS_CLEARED;
            return r;
        end
        if (!(act inside {ACT_INSERT, ACT_SEARCH}) || cfg_hash_divisor == 0 || size == 0)
            return r;
        home = int'(key) % int'(cfg_hash_divisor);
        if (home >= size)
            return r;
        if (act == ACT_INSERT)
        begin
            pos = home;
            if (occupied[home])
            begin
                pos = (home + 1) % size;
                while (pos != home && occupied[pos])
                    pos = (pos + 1) % size;
                if (pos == home)
                begin
                    r.status = STS_FULL;
                    return r;
                end
            end
            stored_key[pos] = key;
            occupied[pos] = 1'b1;
            r.slot = pos[6:0];
            r.status = STS_INSERTED;
            return r;
        end
        comps = 0;
        pos = home;
        while (occupied[pos] && comps < size)
        begin
            comps++;
            if (stored_key[pos] == key)
            begin
                r.slot = pos[6:0];
                r.comps = comps[7:0];
                r.status = STS_FOUND;
                return r;
            end
            pos = (pos + 1) % size;
        end
        r.comps = comps[7:0];
        r.status = STS_NOT_FOUND;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_reply_t want;
        if (!rst_n)
        begin
            cfg_table_size = 8'd128;
            cfg_hash_divisor = 8'd127;
            occupied = '0;
            pending_replies.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            // Responses are handled before requests: a response can never
            // belong to a request accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: response with none outstanding, expected none, actual %h/%h",
                             $time, m_axis_tdata, m_axis_tuser);
                    failures++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("slot", want.slot, m_axis_tdata[6:0]);
                    check_field("comparisons", want.comps, m_axis_tdata[14:7]);
                    check_field("status", want.status, m_axis_tuser);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_replies.push_back(probe_table(s_axis_tuser, s_axis_tdata[14:0]));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_TABLE_SIZE)
                    cfg_table_size = pwdata[7:0];
                else
                    cfg_hash_divisor = pwdata[7:0];
            end
            outstanding <= pending_replies.size();
        end
    end

endmodule

// ===== tb/tb_linear_probe_hash_table_top.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives inserts, searches, clears and unused actions through the request stream under a
// range of table sizes and divisors, with random gaps on both streams; the
// checker instance predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_linear_probe_hash_table_top;
    import lpht_pkg::*;

    // The action field has one code the package does not name; it must be
    // answered with a bad-config status.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // The run limit allows for every request being a full-table search plus the
    // longest sender gap and receiver stall, with a wide margin.
    localparam int LIMIT_CYCLES = 2000000;
    // Cycles allowed after the last response for any stray one to show up.
    localparam int TAIL_CYCLES  = 300;
    localparam int PHASES       = 25;
    localparam int PHASE_ITEMS  = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // key[14:0], zero pad
    logic [1:0]  s_axis_tuser = '0;    // action

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // slot[6:0], comparisons[14:7], zero pad
    logic [2:0]  m_axis_tuser;         // status

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          failures;
    int          outstanding;
    int          cycles = 0;

    // When set, the matching side runs back to back with no idle cycles.
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    logic [14:0] key_pool [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_probe_hash_table_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lpht_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // The run is abandoned if it goes far past the slowest correct run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb_linear_probe_hash_table_top NOT OK");
            $finish;
        end
    end

    // Response side: before every transfer it may hold tready low for a
    // random number of cycles. tready is left high across back-to-back
    // transfers so it is never dropped and raised in the same step.
    initial
    begin
        int stall;
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Sends one request and returns in the step of the edge that accepted it.
    // tvalid stays high when the next request follows with no gap.
    task automatic send_request(input logic [1:0] act, input logic [14:0] key);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Lowers tvalid and waits until every predicted response has arrived.
    // The checker's count is registered, so the loop waits on the clock before its first look.
    // The block is then given time to settle before any register write.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    // The upper bits of pwdata carry noise, since only the low byte counts.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        logic [23:0] noise;
        noise = 24'($urandom);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reconfigure(input logic [7:0] size, input logic [7:0] divisor);
        wait_until_idle();
        write_reg(REG_TABLE_SIZE, size);
        write_reg(REG_HASH_DIVISOR, divisor);
    endtask

    initial
    begin
        int          pick;
        int          roll;
        logic [7:0]  size;
        logic [7:0]  divisor;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first under the reset registers (128 slots, divisor
        // 127). Key 0 and 127 share home slot 0, and key 32767 lands on slot 1, so
        // the third insert has to probe past both.
        send_request(ACT_INSERT, 15'd0);
        send_request(ACT_INSERT, 15'd32767);
        send_request(ACT_INSERT, 15'd127);
        send_request(ACT_SEARCH, 15'd127);
        send_request(ACT_SEARCH, 15'd254);
        send_request(ACT_SEARCH, 15'd32767);
        send_request(ACT_UNUSED, 15'h5555);
        // A duplicate key is stored a second time.
        send_request(ACT_INSERT, 15'd0);
        send_request(ACT_SEARCH, 15'h2AAA);
        send_request(ACT_CLEAR,  15'h7FFF);
        send_request(ACT_SEARCH, 15'd0);

        // Four slots: fill them from one home slot, then an insert into the
        // full table and searches that run all the way round.
        reconfigure(8'd4, 8'd4);
        send_request(ACT_INSERT, 15'd1);
        send_request(ACT_INSERT, 15'd5);
        send_request(ACT_INSERT, 15'd9);
        send_request(ACT_INSERT, 15'd13);
        send_request(ACT_INSERT, 15'd2);
        send_request(ACT_SEARCH, 15'd13);
        send_request(ACT_SEARCH, 15'd17);

        // A zero table size rejects inserts, but a clear still works.
        reconfigure(8'd0, 8'd127);
        send_request(ACT_INSERT, 15'd3);
        send_request(ACT_CLEAR,  15'd0);

        // A zero divisor rejects searches.
        reconfigure(8'd128, 8'd0);
        send_request(ACT_SEARCH, 15'd5);

        // An oversized table saturates to the full depth; the second insert
        // wraps from the last slot back to slot 0.
        reconfigure(8'd255, 8'd128);
        send_request(ACT_INSERT, 15'd127);
        send_request(ACT_INSERT, 15'd255);
        send_request(ACT_SEARCH, 15'd255);

        // A home slot beyond the table size is a bad configuration.
        reconfigure(8'd100, 8'd128);
        send_request(ACT_INSERT, 15'd120);

        // Smallest table: one slot, divisor 1.
        reconfigure(8'd1, 8'd1);
        send_request(ACT_CLEAR,  15'd0);
        send_request(ACT_INSERT, 15'd7);
        send_request(ACT_SEARCH, 15'd7);

        // Random part. Each phase picks a setting, mostly small tables that
        // fill up so probe runs get long and full answers appear. Requests
        // mostly reuse a small key pool so searches find what was inserted.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    size = 8'd128;
                    divisor = 8'($urandom_range(1, 128));
                end
                1:
                begin
                    size = 8'd1;
                    divisor = 8'($urandom_range(1, 2));
                end
                2:
                begin
                    size = 8'($urandom_range(129, 255));
                    divisor = 8'($urandom_range(1, 128));
                end
                3:
                begin
                    size = 8'($urandom_range(0, 128));
                    divisor = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    size = 8'($urandom_range(2, 24));
                    divisor = 8'($urandom_range(1, size));
                end
            endcase
            reconfigure(size, divisor);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
                send_request(ACT_CLEAR, 15'($urandom_range(0, 32767)));
            for (int i = 0; i < 8; i++)
                key_pool[i] = 15'((i < 4) ? $urandom_range(0, 255) : $urandom_range(0, 32767));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    send_request(ACT_INSERT, key_pool[3'($urandom_range(0, 7))]);
                else if (roll < 85)
                    send_request(ACT_SEARCH, key_pool[3'($urandom_range(0, 7))]);
                else if (roll < 91)
                    send_request(ACT_SEARCH, 15'($urandom_range(0, 32767)));
                else if (roll < 94)
                    send_request(ACT_INSERT, 15'($urandom_range(0, 32767)));
                else if (roll < 97)
                    send_request(ACT_CLEAR, 15'($urandom_range(0, 32767)));
                else
                    send_request(ACT_UNUSED, 15'($urandom_range(0, 32767)));
            end
        end

        // Let every response come back, then watch a while for strays.
        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("tb_linear_probe_hash_table_top OK");
        else
            $display("tb_linear_probe_hash_table_top NOT OK");
        $finish;
    end

endmodule
